// ===== rtl/core/icpc_pkg.sv =====
package icpc_pkg;

  // Item kinds carried on tuser
  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_PUMP   = 2'd1,
    KIND_TOGGLE = 2'd2,
    KIND_TICK   = 2'd3
  } kind_t;

  // Soil status codes
  localparam logic [1:0] SOIL_DRY    = 2'd0;
  localparam logic [1:0] SOIL_MOIST  = 2'd1;
  localparam logic [1:0] SOIL_SOAKED = 2'd2;

  // Register indexes (byte address is 4x index)
  typedef enum logic [2:0] {
    REG_SOIL_DRY   = 3'd0,
    REG_SOIL_MOIST = 3'd1,
    REG_WATER_STOP = 3'd2,
    REG_OVR_LIMIT  = 3'd3,
    REG_TRAVEL     = 3'd4
  } reg_idx_t;

  localparam int AddrW   = 5;
  localparam int DataW   = 32;
  localparam int InDataW = 32;
  localparam int OutDataW = 24;

  localparam logic [11:0] SoilDryRst   = 12'd2300;
  localparam logic [11:0] SoilMoistRst = 12'd1850;
  localparam logic [12:0] WaterStopRst = 13'd336;   // 21.0 cm in 1/16 cm
  localparam logic [21:0] OvrLimitRst  = 22'd3600000;
  localparam logic [15:0] TravelRst    = 16'd4096;
  localparam logic [21:0] ElapsedMax   = 22'h3FFFFF;

  typedef struct packed {
    logic [11:0] soil_dry_threshold;
    logic [11:0] soil_moist_threshold;
    logic [12:0] water_stop_level;
    logic [21:0] override_limit_ms;
    logic [15:0] cover_travel_steps;
  } cfg_t;

  typedef struct packed {
    kind_t       req_type;
    logic [11:0] soil_adc;
    logic        rain_dry;
    logic [12:0] water_distance;
  } in_item_t;

  typedef struct packed {
    kind_t              result_kind;
    logic               pump_on;
    logic [1:0]         soil_status;
    logic               cover_open;
    logic signed [16:0] cover_move;
    logic               manual_mode;
    logic               pump_pulse;
  } out_item_t;

endpackage

// ===== rtl/core/irrigation_cover_pump_controller_unit.sv =====
// Irrigation cover and pump controller. Each input beat (sensor sample, manual pump
// command, manual cover toggle or 1 ms tick, chosen by in_tuser) yields exactly one
// result beat, via the input register and then the result register. One beat is
// taken every cycle while the output is not stalled: the input register feeds combinational
// compare logic that updates the controller state and loads the result register, and both
// stages advance together under output backpressure. Thresholds, override limit and cover travel
// are set over the APB port at byte addresses 0x00..0x10; write them only while idle.
module irrigation_cover_pump_controller_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [icpc_pkg::InDataW-1:0]   in_tdata,  // soil_adc[11:0], rain_dry[12], water_distance[25:13]
  input  logic [1:0]                     in_tuser,  // req_type[1:0]
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [icpc_pkg::OutDataW-1:0]  out_tdata, // pump_on[0], soil_status[2:1], cover_open[3],
                                                    // cover_move[20:4], manual_mode[21], pump_pulse[22]
  output logic [1:0]                     out_tuser, // result_kind[1:0]
  // configuration
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [icpc_pkg::AddrW-1:0]     cfg_paddr,
  input  logic [icpc_pkg::DataW-1:0]     cfg_pwdata,
  output logic [icpc_pkg::DataW-1:0]     cfg_prdata,
  output logic                           cfg_pready
);

  icpc_pkg::cfg_t      cfg;
  icpc_pkg::in_item_t  item_r;
  icpc_pkg::out_item_t res, res_r;
  logic                s1_vld_r, out_vld_r;
  logic                out_free, s1_adv;

  assign cfg_pready = 1'b1;

  icpc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // Pipeline flow control; no beat is taken while in reset
  assign out_free  = !out_vld_r || out_tready;
  assign s1_adv    = s1_vld_r && out_free;
  assign in_tready = rst_n && (!s1_vld_r || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) s1_vld_r <= in_tvalid;
      if (out_free)  out_vld_r <= s1_vld_r;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.req_type       <= icpc_pkg::kind_t'(in_tuser);
      item_r.soil_adc       <= in_tdata[11:0];
      item_r.rain_dry       <= in_tdata[12];
      item_r.water_distance <= in_tdata[25:13];
    end
  end

  icpc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_adv),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (s1_adv) res_r <= res;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = res_r.result_kind;
  assign out_tdata  = {1'b0, res_r.pump_pulse, res_r.manual_mode, res_r.cover_move,
                       res_r.cover_open, res_r.soil_status, res_r.pump_on};

endmodule

// ===== rtl/core/icpc_regs.sv =====
module icpc_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [icpc_pkg::AddrW-1:0]  paddr,
  input  logic [icpc_pkg::DataW-1:0]  pwdata,
  output logic [icpc_pkg::DataW-1:0]  prdata,
  output icpc_pkg::cfg_t              cfg
);

  icpc_pkg::cfg_t     cfg_r;
  icpc_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx   = icpc_pkg::reg_idx_t'(paddr[icpc_pkg::AddrW-1:2]);
  assign wr_en = psel & penable & pwrite;
  assign cfg   = cfg_r;

  // Register writes on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.soil_dry_threshold   <= icpc_pkg::SoilDryRst;
      cfg_r.soil_moist_threshold <= icpc_pkg::SoilMoistRst;
      cfg_r.water_stop_level     <= icpc_pkg::WaterStopRst;
      cfg_r.override_limit_ms    <= icpc_pkg::OvrLimitRst;
      cfg_r.cover_travel_steps   <= icpc_pkg::TravelRst;
    end else if (wr_en) begin
      unique case (idx)
        icpc_pkg::REG_SOIL_DRY:   cfg_r.soil_dry_threshold   <= pwdata[11:0];
        icpc_pkg::REG_SOIL_MOIST: cfg_r.soil_moist_threshold <= pwdata[11:0];
        icpc_pkg::REG_WATER_STOP: cfg_r.water_stop_level     <= pwdata[12:0];
        icpc_pkg::REG_OVR_LIMIT:  cfg_r.override_limit_ms    <= pwdata[21:0];
        icpc_pkg::REG_TRAVEL:     cfg_r.cover_travel_steps   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    unique case (idx)
      icpc_pkg::REG_SOIL_DRY:   prdata = {20'd0, cfg_r.soil_dry_threshold};
      icpc_pkg::REG_SOIL_MOIST: prdata = {20'd0, cfg_r.soil_moist_threshold};
      icpc_pkg::REG_WATER_STOP: prdata = {19'd0, cfg_r.water_stop_level};
      icpc_pkg::REG_OVR_LIMIT:  prdata = {10'd0, cfg_r.override_limit_ms};
      icpc_pkg::REG_TRAVEL:     prdata = {16'd0, cfg_r.cover_travel_steps};
      default:                  prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/icpc_core.sv =====
module icpc_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  icpc_pkg::in_item_t   item,
  input  icpc_pkg::cfg_t       cfg,
  output icpc_pkg::out_item_t  res
);

  logic        cover_closed_r, cover_closed_nxt;
  logic        ovr_active_r, ovr_active_nxt;
  logic [21:0] elapsed_r, elapsed_nxt;
  logic        relay_r, relay_nxt;
  logic [1:0]  soil_st_r, soil_st_nxt;

  logic signed [16:0] close_mv, open_mv, move;
  logic        pulse;
  logic        soil_over_dry;
  logic [21:0] elapsed_inc;

  assign close_mv      = signed'({1'b0, cfg.cover_travel_steps});
  assign open_mv       = -close_mv;
  assign soil_over_dry = item.soil_adc > cfg.soil_dry_threshold;
  assign elapsed_inc   = (elapsed_r == icpc_pkg::ElapsedMax) ? elapsed_r : elapsed_r + 22'd1;

  // Next state and result for one item
  always_comb begin
    cover_closed_nxt = cover_closed_r;
    ovr_active_nxt   = ovr_active_r;
    elapsed_nxt      = elapsed_r;
    relay_nxt        = relay_r;
    soil_st_nxt      = soil_st_r;
    move             = '0;
    pulse            = 1'b0;
    unique case (item.req_type)
      icpc_pkg::KIND_SAMPLE: begin
        if (!ovr_active_r) begin
          if (!item.rain_dry && !cover_closed_r) begin
            move             = close_mv;
            cover_closed_nxt = 1'b1;
          end else if (item.rain_dry && cover_closed_r) begin
            move             = open_mv;
            cover_closed_nxt = 1'b0;
          end
        end
        relay_nxt = (item.water_distance >= cfg.water_stop_level) ? 1'b0 : soil_over_dry;
        priority if (soil_over_dry) begin
          soil_st_nxt = icpc_pkg::SOIL_DRY;
        end else if (item.soil_adc >= cfg.soil_moist_threshold) begin
          soil_st_nxt = icpc_pkg::SOIL_MOIST;
        end else begin
          soil_st_nxt = icpc_pkg::SOIL_SOAKED;
        end
      end
      icpc_pkg::KIND_PUMP: begin
        pulse     = 1'b1;
        relay_nxt = 1'b0;
      end
      icpc_pkg::KIND_TOGGLE: begin
        move             = cover_closed_r ? open_mv : close_mv;
        cover_closed_nxt = !cover_closed_r;
        ovr_active_nxt   = 1'b1;
        elapsed_nxt      = '0;
      end
      icpc_pkg::KIND_TICK: begin
        if (ovr_active_r) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc > cfg.override_limit_ms) ovr_active_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cover_closed_r <= 1'b0;
      ovr_active_r   <= 1'b0;
      elapsed_r      <= '0;
      relay_r        <= 1'b0;
      soil_st_r      <= icpc_pkg::SOIL_DRY;
    end else if (step_en) begin
      cover_closed_r <= cover_closed_nxt;
      ovr_active_r   <= ovr_active_nxt;
      elapsed_r      <= elapsed_nxt;
      relay_r        <= relay_nxt;
      soil_st_r      <= soil_st_nxt;
    end
  end

  assign res.result_kind = item.req_type;
  assign res.pump_on     = relay_nxt;
  assign res.soil_status = soil_st_nxt;
  assign res.cover_open  = !cover_closed_nxt;
  assign res.cover_move  = move;
  assign res.manual_mode = ovr_active_nxt;
  assign res.pump_pulse  = pulse;

endmodule

// ===== rtl/core/icpc_chk.sv =====
module icpc_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [icpc_pkg::OutDataW-1:0] out_tdata,
  input logic [1:0]                    out_tuser
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Pulse only on manual pump beats, with relay low
  a_pulse_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[22] |-> out_tuser == icpc_pkg::KIND_PUMP && !out_tdata[0])
    else $error("pump pulse on wrong beat");

  // Cover moves only on samples and toggles
  a_move_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20:4] != 17'd0 |->
      out_tuser == icpc_pkg::KIND_SAMPLE || out_tuser == icpc_pkg::KIND_TOGGLE)
    else $error("cover move on wrong beat");

  // A toggle always enters manual override
  a_toggle_manual: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == icpc_pkg::KIND_TOGGLE |-> out_tdata[21])
    else $error("toggle without override");

  // Soil status never reports the unused code
  a_soil_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:1] != 2'd3)
    else $error("bad soil status");

endmodule

bind irrigation_cover_pump_controller_unit icpc_chk u_icpc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
